@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CHK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/trmt_pkg.sv @@
// Shared types, constants and fixed-point helpers for the midpoint triangulator.
// Depends on nothing.
`default_nettype none
package trmt_pkg;

    localparam int DATA_W      = 32;
    localparam int POSE_WORDS  = 12;
    localparam int DIV_STEPS   = 48;
    localparam int CFG_IDX_W   = 4;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_TRI  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_INV_FOCAL_X   = 4'd0,
        REG_INV_FOCAL_Y   = 4'd1,
        REG_CENTER_OFF_X  = 4'd2,
        REG_CENTER_OFF_Y  = 4'd3
    } reg_idx_t;

    typedef logic [15:0] coord_t;

    typedef struct packed
    {
        cmd_t               cmd;
        logic [3:0]         idx;
        logic signed [31:0] value;
        coord_t             x0;
        coord_t             y0;
        coord_t             x1;
        coord_t             y1;
    } item_t;

    typedef struct packed
    {
        logic signed [31:0] inv_fx;
        logic signed [31:0] inv_fy;
        logic signed [31:0] off_x;
        logic signed [31:0] off_y;
    } cfg_t;

    localparam logic signed [65:0] MAX66 = 66'sd2147483647;
    localparam logic signed [65:0] MIN66 = -66'sd2147483648;

    // Clamp a wide signed value into the 32-bit Q16.16 range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > MAX66)
            r = 32'sh7FFFFFFF;
        else if (v < MIN66)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/trmt_fifo.sv @@
// Small synchronous queue with full/empty flags and a combinational head.
// Depends on nothing.
`default_nettype none
module trmt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] din,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      dout,
    output logic              empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

@@ rtl/trmt_front.sv @@
// Front end: takes input beats, drops loads outside the pose table, packs items.
// Depends on trmt_pkg.
`default_nettype none
module trmt_front #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  push,
    input  wire logic                  q_full,
    input  wire logic                  command,
    input  wire logic [3:0]            coef_index,
    input  wire logic signed [31:0]    coef_value,
    input  wire logic [COORD_BITS-1:0] first_x,
    input  wire logic [COORD_BITS-1:0] first_y,
    input  wire logic [COORD_BITS-1:0] second_x,
    input  wire logic [COORD_BITS-1:0] second_y,
    output logic                       q_push,
    output trmt_pkg::item_t            q_item
);
    logic keep;

    always_comb
    begin
        q_item.cmd   = trmt_pkg::cmd_t'(command);
        q_item.idx   = coef_index;
        q_item.value = coef_value;
        q_item.x0    = trmt_pkg::coord_t'(first_x);
        q_item.y0    = trmt_pkg::coord_t'(first_y);
        q_item.x1    = trmt_pkg::coord_t'(second_x);
        q_item.y1    = trmt_pkg::coord_t'(second_y);
        // A load aimed past the table has no effect, so it never enters the queue.
        keep = (q_item.cmd == trmt_pkg::CMD_TRI) ||
               (coef_index < 4'(trmt_pkg::POSE_WORDS));
        q_push = push && !q_full && keep;
    end
endmodule
`default_nettype wire

@@ rtl/trmt_div.sv @@
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on trmt_pkg.
`default_nettype none
module trmt_div #(
    parameter int SIDE_W = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] num_a,
    input  wire logic signed [31:0] num_b,
    input  wire logic [31:0]        den,
    input  wire logic [SIDE_W-1:0]  side_in,
    output logic                    out_valid,
    output logic [47:0]             quo_a,
    output logic [47:0]             quo_b,
    output logic                    neg_a,
    output logic                    neg_b,
    output logic [SIDE_W-1:0]       side_out
);
    localparam int N = trmt_pkg::DIV_STEPS;

    logic [N:0]        vld_reg;
    logic [31:0]       rema_reg [N+1];
    logic [31:0]       remb_reg [N+1];
    logic [47:0]       dqa_reg  [N+1];
    logic [47:0]       dqb_reg  [N+1];
    logic [31:0]       den_reg  [N+1];
    logic [N:0]        nga_reg, ngb_reg;
    logic [SIDE_W-1:0] side_reg [N+1];
    logic [31:0]       mag_a, mag_b;

    function automatic logic [79:0] div_step(input logic [31:0] rem, input logic [47:0] dq,
                                             input logic [31:0] dv);
        logic [32:0] tmp;
        logic [32:0] dif;
        tmp = {rem, dq[47]};
        dif = tmp - {1'b0, dv};
        if (!dif[32])
            return {dif[31:0], dq[46:0], 1'b1};
        else
            return {tmp[31:0], dq[46:0], 1'b0};
    endfunction

    assign mag_a = num_a[31] ? (~num_a + 32'd1) : num_a;
    assign mag_b = num_b[31] ? (~num_b + 32'd1) : num_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rema_reg[0] <= '0;
            remb_reg[0] <= '0;
            dqa_reg[0]  <= {mag_a, 16'd0};
            dqb_reg[0]  <= {mag_b, 16'd0};
            den_reg[0]  <= den;
            nga_reg[0]  <= num_a[31];
            ngb_reg[0]  <= num_b[31];
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                {rema_reg[k+1], dqa_reg[k+1]} <= div_step(rema_reg[k], dqa_reg[k], den_reg[k]);
                {remb_reg[k+1], dqb_reg[k+1]} <= div_step(remb_reg[k], dqb_reg[k], den_reg[k]);
                den_reg[k+1]  <= den_reg[k];
                nga_reg[k+1]  <= nga_reg[k];
                ngb_reg[k+1]  <= ngb_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign quo_a     = dqa_reg[N];
    assign quo_b     = dqb_reg[N];
    assign neg_a     = nga_reg[N];
    assign neg_b     = ngb_reg[N];
    assign side_out  = side_reg[N];
endmodule
`default_nettype wire

@@ rtl/trmt_back.sv @@
// Back end: pose table, ray construction, cross/dot products, division, depth.
// Depends on trmt_pkg and trmt_div.
`default_nettype none
module trmt_back #(
    parameter int COORD_BITS = 12
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire trmt_pkg::cfg_t  cfg,
    input  wire trmt_pkg::item_t q_item,
    input  wire logic            q_empty,
    output logic                 q_pop,
    input  wire logic            o_full,
    output logic                 o_push,
    output logic signed [31:0]   o_depth,
    output logic                 o_parallel,
    output logic                 o_behind
);
    localparam int SIDE_W = 65;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic v9_reg, v10_reg, v11_reg;

    logic signed [31:0] pose_reg [trmt_pkg::POSE_WORDS];

    // stage 1
    logic [COORD_BITS-1:0] x0_1_reg, y0_1_reg, x1_1_reg, y1_1_reg;
    logic signed [31:0]    rot1_reg [9];
    logic signed [31:0]    trn1_reg [3];
    // stage 2
    logic signed [31:0]    r0_2_reg, r1_2_reg, sp0_2_reg, sp1_2_reg;
    logic signed [31:0]    rot2_reg [9];
    logic signed [31:0]    trn2_reg [3];
    // stage 3
    logic signed [63:0]    pa3_reg [3];
    logic signed [63:0]    pb3_reg [3];
    logic signed [31:0]    rc3_reg [3];
    logic signed [31:0]    r0_3_reg, r1_3_reg;
    logic signed [31:0]    trn3_reg [3];
    // stage 4
    logic signed [31:0]    s4_reg [3];
    logic signed [31:0]    r0_4_reg, r1_4_reg;
    logic signed [31:0]    trn4_reg [3];
    // stage 5: raw products of the three cross products
    logic signed [63:0]    m_r1s2_reg, m_r0s2_reg, m_r0s1_reg, m_r1s0_reg;
    logic signed [63:0]    m_t1s2_reg, m_t2s1_reg, m_t2s0_reg, m_t0s2_reg;
    logic signed [63:0]    m_t0s1_reg, m_t1s0_reg;
    logic signed [63:0]    m_t2r1_reg, m_t2r0_reg, m_t0r1_reg, m_t1r0_reg;
    logic signed [31:0]    s5_reg [3];
    logic signed [31:0]    trn5_reg [3];
    // stage 6
    logic signed [31:0]    c6_reg [3];
    logic signed [31:0]    u6_reg [3];
    logic signed [31:0]    w6_reg [3];
    logic signed [31:0]    t2_6_reg, s2_6_reg;
    // stage 7
    logic signed [63:0]    cc7_reg [3];
    logic signed [63:0]    uc7_reg [3];
    logic signed [63:0]    wc7_reg [3];
    logic signed [31:0]    t2_7_reg, s2_7_reg;
    // stage 8
    logic signed [31:0]    d8_reg, na8_reg, nb8_reg;
    logic signed [31:0]    t2_8_reg, s2_8_reg;
    // divider outputs
    logic                  dv_valid, dv_nega, dv_negb;
    logic [47:0]           dv_qa, dv_qb;
    logic [SIDE_W-1:0]     dv_side;
    // stage 9..11
    logic signed [31:0]    a9_reg, b9_reg, t2_9_reg, s2_9_reg;
    logic                  par9_reg;
    logic signed [63:0]    pbs10_reg;
    logic signed [31:0]    a10_reg, t2_10_reg;
    logic                  par10_reg;
    logic signed [31:0]    depth11_reg;
    logic                  par11_reg, behind11_reg;

    logic signed [65:0]    z_sum;
    logic signed [31:0]    depth_next;

    function automatic logic signed [31:0] ray(input logic signed [31:0] k,
                                               input logic signed [31:0] off,
                                               input logic [COORD_BITS-1:0] x);
        logic signed [COORD_BITS+32:0] m;
        m = k * $signed({1'b0, x});
        return trmt_pkg::sat32(66'(m) + 66'(off));
    endfunction

    function automatic logic signed [31:0] xterm(input logic signed [63:0] p,
                                                 input logic signed [63:0] q);
        logic signed [65:0] dif;
        dif = 66'(p) - 66'(q);
        return trmt_pkg::sat32(dif >>> 16);
    endfunction

    function automatic logic signed [63:0] shl16(input logic signed [31:0] s);
        return 64'(s) <<< 16;
    endfunction

    function automatic logic signed [31:0] dsum(input logic signed [63:0] p0,
                                                input logic signed [63:0] p1,
                                                input logic signed [63:0] p2);
        return trmt_pkg::sat32(66'(p0 >>> 16) + 66'(p1 >>> 16) + 66'(p2 >>> 16));
    endfunction

    function automatic logic signed [31:0] sat_quo(input logic [47:0] q, input logic neg);
        logic signed [31:0] r;
        if (!neg)
            r = (q > 48'h0000_7FFF_FFFF) ? 32'sh7FFFFFFF : $signed(q[31:0]);
        else
            r = (q > 48'h0000_8000_0000) ? 32'sh80000000 : $signed(~q[31:0] + 32'd1);
        return r;
    endfunction

    assign en     = !(v11_reg && o_full);
    assign q_pop  = en && !q_empty;
    assign o_push = v11_reg && !o_full;
    assign o_depth    = depth11_reg;
    assign o_parallel = par11_reg;
    assign o_behind   = behind11_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.cmd == trmt_pkg::CMD_LOAD &&
            q_item.idx < 4'(trmt_pkg::POSE_WORDS))
            pose_reg[q_item.idx] <= q_item.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= q_pop && (q_item.cmd == trmt_pkg::CMD_TRI);
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= dv_valid;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
        end
    end

    always_comb
    begin
        z_sum = 66'(t2_10_reg) + 66'(a10_reg) + 66'(pbs10_reg >>> 16);
        depth_next = trmt_pkg::sat32(z_sum >>> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Snapshot of the pose so that later loads cannot disturb this pair.
            x0_1_reg <= q_item.x0[COORD_BITS-1:0];
            y0_1_reg <= q_item.y0[COORD_BITS-1:0];
            x1_1_reg <= q_item.x1[COORD_BITS-1:0];
            y1_1_reg <= q_item.y1[COORD_BITS-1:0];
            for (int i = 0; i < 9; i++)
                rot1_reg[i] <= pose_reg[i];
            for (int i = 0; i < 3; i++)
                trn1_reg[i] <= pose_reg[9+i];

            r0_2_reg  <= ray(cfg.inv_fx, cfg.off_x, x0_1_reg);
            r1_2_reg  <= ray(cfg.inv_fy, cfg.off_y, y0_1_reg);
            sp0_2_reg <= ray(cfg.inv_fx, cfg.off_x, x1_1_reg);
            sp1_2_reg <= ray(cfg.inv_fy, cfg.off_y, y1_1_reg);
            rot2_reg  <= rot1_reg;
            trn2_reg  <= trn1_reg;

            for (int i = 0; i < 3; i++)
            begin
                pa3_reg[i] <= rot2_reg[i] * sp0_2_reg;
                pb3_reg[i] <= rot2_reg[3+i] * sp1_2_reg;
                rc3_reg[i] <= rot2_reg[6+i];
            end
            r0_3_reg <= r0_2_reg;
            r1_3_reg <= r1_2_reg;
            trn3_reg <= trn2_reg;

            for (int i = 0; i < 3; i++)
                s4_reg[i] <= trmt_pkg::sat32(66'(pa3_reg[i] >>> 16) +
                                             66'(pb3_reg[i] >>> 16) + 66'(rc3_reg[i]));
            r0_4_reg <= r0_3_reg;
            r1_4_reg <= r1_3_reg;
            trn4_reg <= trn3_reg;

            m_r1s2_reg <= r1_4_reg * s4_reg[2];
            m_r0s2_reg <= r0_4_reg * s4_reg[2];
            m_r0s1_reg <= r0_4_reg * s4_reg[1];
            m_r1s0_reg <= r1_4_reg * s4_reg[0];
            m_t1s2_reg <= trn4_reg[1] * s4_reg[2];
            m_t2s1_reg <= trn4_reg[2] * s4_reg[1];
            m_t2s0_reg <= trn4_reg[2] * s4_reg[0];
            m_t0s2_reg <= trn4_reg[0] * s4_reg[2];
            m_t0s1_reg <= trn4_reg[0] * s4_reg[1];
            m_t1s0_reg <= trn4_reg[1] * s4_reg[0];
            m_t2r1_reg <= trn4_reg[2] * r1_4_reg;
            m_t2r0_reg <= trn4_reg[2] * r0_4_reg;
            m_t0r1_reg <= trn4_reg[0] * r1_4_reg;
            m_t1r0_reg <= trn4_reg[1] * r0_4_reg;
            s5_reg   <= s4_reg;
            trn5_reg <= trn4_reg;

            // The z component of the first ray is exactly one, so its products are shifts.
            c6_reg[0] <= xterm(m_r1s2_reg, shl16(s5_reg[1]));
            c6_reg[1] <= xterm(shl16(s5_reg[0]), m_r0s2_reg);
            c6_reg[2] <= xterm(m_r0s1_reg, m_r1s0_reg);
            u6_reg[0] <= xterm(m_t1s2_reg, m_t2s1_reg);
            u6_reg[1] <= xterm(m_t2s0_reg, m_t0s2_reg);
            u6_reg[2] <= xterm(m_t0s1_reg, m_t1s0_reg);
            w6_reg[0] <= xterm(shl16(trn5_reg[1]), m_t2r1_reg);
            w6_reg[1] <= xterm(m_t2r0_reg, shl16(trn5_reg[0]));
            w6_reg[2] <= xterm(m_t0r1_reg, m_t1r0_reg);
            t2_6_reg  <= trn5_reg[2];
            s2_6_reg  <= s5_reg[2];

            for (int i = 0; i < 3; i++)
            begin
                cc7_reg[i] <= c6_reg[i] * c6_reg[i];
                uc7_reg[i] <= u6_reg[i] * c6_reg[i];
                wc7_reg[i] <= w6_reg[i] * c6_reg[i];
            end
            t2_7_reg <= t2_6_reg;
            s2_7_reg <= s2_6_reg;

            d8_reg   <= dsum(cc7_reg[0], cc7_reg[1], cc7_reg[2]);
            na8_reg  <= dsum(uc7_reg[0], uc7_reg[1], uc7_reg[2]);
            nb8_reg  <= dsum(wc7_reg[0], wc7_reg[1], wc7_reg[2]);
            t2_8_reg <= t2_7_reg;
            s2_8_reg <= s2_7_reg;

            a9_reg   <= sat_quo(dv_qa, dv_nega);
            b9_reg   <= sat_quo(dv_qb, dv_negb);
            {par9_reg, t2_9_reg, s2_9_reg} <= dv_side;

            pbs10_reg <= b9_reg * s2_9_reg;
            a10_reg   <= a9_reg;
            t2_10_reg <= t2_9_reg;
            par10_reg <= par9_reg;

            par11_reg    <= par10_reg;
            depth11_reg  <= par10_reg ? 32'sd0 : depth_next;
            behind11_reg <= !par10_reg && depth_next[31];
        end
    end

    trmt_div #(
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v8_reg),
        .num_a     (na8_reg),
        .num_b     (nb8_reg),
        .den       (d8_reg),
        .side_in   ({d8_reg == 32'sd0, t2_8_reg, s2_8_reg}),
        .out_valid (dv_valid),
        .quo_a     (dv_qa),
        .quo_b     (dv_qb),
        .neg_a     (dv_nega),
        .neg_b     (dv_negb),
        .side_out  (dv_side)
    );
endmodule
`default_nettype wire

@@ rtl/two_ray_midpoint_triangulation.sv @@
// Two-ray midpoint triangulator: one matched pixel pair per beat in, one depth per pair out.
// Ports are queue-like on both sides: a beat enters while full is low and leaves while empty
// is low. Load beats (command 0) write one word of the pose (rotation row-major at indexes
// 0..8, translation x, y, z at 9..11) and produce no result; loads to indexes 12..15 do
// nothing. Triangulate beats (command 1) return the Q16.16 depth of the midpoint of the
// closest points between the two back-projected rays, with parallel_rays set and depth zero
// when the rays are parallel, and behind_camera set when depth is negative. Every pose word
// must be loaded before the first triangulate beat. The block takes one beat per clock
// cycle, loads and pairs alike, whenever neither side stalls; a pair's result passes through
// the 48 one-bit stages of the pipelined divider that forms the two ray parameters. Loads
// travel through the same queue as pairs, so a pose change takes effect exactly between the
// pairs where it was sent. The four intrinsic registers are written over the cfg port, which
// is always ready, and may only change while no pair is in flight. Depends on trmt_pkg,
// trmt_front, trmt_fifo and trmt_back.
`default_nettype none
module two_ray_midpoint_triangulation #(
    parameter int COORD_BITS  = 12,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input queue side
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  command,
    input  wire logic [3:0]            coef_index,
    input  wire logic signed [31:0]    coef_value,
    input  wire logic [COORD_BITS-1:0] first_x,
    input  wire logic [COORD_BITS-1:0] first_y,
    input  wire logic [COORD_BITS-1:0] second_x,
    input  wire logic [COORD_BITS-1:0] second_y,
    // result queue side
    output logic                       empty,
    input  wire logic                  pop,
    output logic signed [31:0]         depth,
    output logic                       parallel_rays,
    output logic                       behind_camera,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [trmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]           cfg_data
);
    localparam int IW = $bits(trmt_pkg::item_t);

    trmt_pkg::cfg_t  cfg_reg;
    trmt_pkg::item_t front_item, q_item;
    logic            front_push, q_empty, q_pop;
    logic            o_push, o_full, o_parallel, o_behind;
    logic signed [31:0] o_depth;
    logic [33:0]     o_word;

    // The configuration registers can take a write on every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_fx <= 32'sd106;
            cfg_reg.inv_fy <= 32'sd105;
            cfg_reg.off_x  <= -32'sd30587;
            cfg_reg.off_y  <= -32'sd26188;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                trmt_pkg::REG_INV_FOCAL_X:  cfg_reg.inv_fx <= cfg_data;
                trmt_pkg::REG_INV_FOCAL_Y:  cfg_reg.inv_fy <= cfg_data;
                trmt_pkg::REG_CENTER_OFF_X: cfg_reg.off_x  <= cfg_data;
                trmt_pkg::REG_CENTER_OFF_Y: cfg_reg.off_y  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Front end classifies beats; the item queue decouples it from the arithmetic.
    trmt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .push       (push),
        .q_full     (full),
        .command    (command),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .first_x    (first_x),
        .first_y    (first_y),
        .second_x   (second_x),
        .second_y   (second_y),
        .q_push     (front_push),
        .q_item     (front_item)
    );

    trmt_fifo #(
        .W     (IW),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .din   (front_item),
        .full  (full),
        .pop   (q_pop),
        .dout  (q_item),
        .empty (q_empty)
    );

    trmt_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_item     (q_item),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .o_full     (o_full),
        .o_push     (o_push),
        .o_depth    (o_depth),
        .o_parallel (o_parallel),
        .o_behind   (o_behind)
    );

    // Result queue: the pipeline keeps going while results wait here, until this queue is full.
    trmt_fifo #(
        .W     (34),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .din   ({o_depth, o_parallel, o_behind}),
        .full  (o_full),
        .pop   (pop),
        .dout  (o_word),
        .empty (empty)
    );

    assign depth         = o_word[33:2];
    assign parallel_rays = o_word[1];
    assign behind_camera = o_word[0];
endmodule
`default_nettype wire

@@ rtl/trmt_chk.sv @@
// Port-level checker for the midpoint triangulator, bound to the top level.
// Depends on assert_macros.svh and two_ray_midpoint_triangulation.
`default_nettype none
`include "assert_macros.svh"
module trmt_chk (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic signed [31:0] depth,
    input wire logic               parallel_rays,
    input wire logic               behind_camera,
    input wire logic               cfg_ready
);
    `CHK_ALWAYS(a_reset_empty, clk, (!rst_n) |-> empty, "results present during reset")
    `CHK_ASSERT(a_parallel_zero, clk, rst_n, (!empty && parallel_rays) |-> (depth == 32'sd0 && !behind_camera), "parallel result not zeroed")
    `CHK_ASSERT(a_behind_sign, clk, rst_n, !empty |-> (behind_camera == depth[31]), "behind flag disagrees with depth sign")
    `CHK_ASSERT(a_result_holds, clk, rst_n, (!empty && !pop) |=> !empty, "waiting result vanished")
    `CHK_ASSERT(a_cfg_ready, clk, rst_n, cfg_ready, "configuration port refused a write")
endmodule

bind two_ray_midpoint_triangulation trmt_chk u_trmt_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .depth         (depth),
    .parallel_rays (parallel_rays),
    .behind_camera (behind_camera),
    .cfg_ready     (cfg_ready)
);
`default_nettype wire
